// ----- rtl/jtag_dap_scan_engine_core_assert.svh -----
// Assertion macros for the JTAG scan engine
`ifndef JTAG_DAP_SCAN_ENGINE_CORE_ASSERT_SVH
`define JTAG_DAP_SCAN_ENGINE_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define JDSE_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define JDSE_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/jdse_pkg.sv -----
//------------------------------------------------------------------------------
// jdse_pkg
// Shared types and constants of the JTAG scan engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package jdse_pkg;
    localparam int MaxChainDevices = 8;
    localparam int MaxSeqClocks    = 64;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_SEQ = 3'd1, OP_IDCODE = 3'd2,
        OP_ABORT = 3'd3, OP_IR = 3'd4, OP_XFER = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0, PH_SEQ = 4'd1, PH_HEAD = 4'd2, PH_PRE = 4'd3,
        PH_REQ = 4'd4, PH_DATA = 4'd5, PH_POST = 4'd6, PH_EXIT = 4'd7,
        PH_ABORT = 4'd8, PH_RTI = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        REG_DEV_POS = 3'd0, REG_DEV_TOTAL = 3'd1, REG_IR_PRE = 3'd2,
        REG_IR_POST = 3'd3, REG_IR_WIDTH = 3'd4, REG_IDLE = 3'd5
    } t_reg;

    localparam logic [2:0] AckOk = 3'd1;

    typedef struct packed {
        logic [2:0] dev_pos;
        logic [3:0] dev_total;
        logic [9:0] ir_pre;
        logic [9:0] ir_post;
        logic [5:0] ir_width;
        logic [7:0] idle_clocks;
    } t_cfg;

    function automatic logic [2:0] ack_remap(input logic [2:0] a);
        logic [2:0] r;
        case (a)
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd5: r = 3'd6;
            3'd6: r = 3'd5;
            default: r = a;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/jtag_dap_scan_engine_core.sv -----
//------------------------------------------------------------------------------
// jtag_dap_scan_engine_core
// JTAG master for one device of a daisy chain, one TCK clock per tick.
//------------------------------------------------------------------------------
// Usage: the input channel (i_valid/o_stall) carries command and tick items.
// A command (opcode 1..5) arms one operation and yields no result. Each tick
// issues one clock: it samples i_tdo_bit and yields one result item on the
// output channel (o_valid/i_stall) with TMS, TDI and, on the last clock of
// the operation, the finished flag, ACK and read data. A tick while idle
// yields a result with clock_active low.
// Output: each result is registered and appears in the cycle after its tick is transferred.
// Throughput: one item per cycle while o_stall is low; the phase sequencer and
// its bit counter compute each tick's next state combinationally.
// Stall: the output register holds while i_stall is high; o_stall rises only
// when that register is full and stalled, so no result is dropped.
// Reset: synchronous, active low; returns to Idle with default registers.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "jtag_dap_scan_engine_core_assert.svh"
module jtag_dap_scan_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic        i_tdo_bit,
    input  wire logic [63:0] i_payload,
    input  wire logic        i_read_not_write,
    input  wire logic [1:0]  i_reg_addr,
    input  wire logic [5:0]  i_seq_clocks,
    input  wire logic        i_seq_tms,
    input  wire logic        i_seq_capture,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tms_bit,
    output logic             o_tdi_bit,
    output logic             o_clock_active,
    output logic             o_finished,
    output logic [2:0]       o_ack_code,
    output logic [63:0]      o_read_value
);
    jdse_pkg::t_cfg cfg;

    jdse_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    jdse_pkg::t_phase r_phase, n_phase;
    logic [10:0] r_cnt, n_cnt;
    logic [63:0] r_sout, n_sout, r_sin, n_sin;
    logic [2:0]  r_op, n_op;
    logic r_rnw, n_rnw, r_stms, n_stms, r_scap, n_scap;
    logic [1:0]  r_addr, n_addr;
    logic [2:0]  r_ack, n_ack;
    logic [5:0]  r_slast, n_slast;

    logic r_ovalid;
    logic r_tms, r_tdi, r_act, r_fin;
    logic [2:0]  r_ackout;
    logic [63:0] r_rv;

    logic take;
    assign o_stall = r_ovalid & i_stall;
    assign take    = i_valid & ~o_stall;

    // derived lengths
    logic [3:0] tot_sat;
    logic [3:0] dev_after;
    logic [5:0] ir_len;
    always_comb begin
        tot_sat = (cfg.dev_total > 4'(jdse_pkg::MaxChainDevices))
                ? 4'(jdse_pkg::MaxChainDevices) : cfg.dev_total;
        dev_after = (tot_sat > ({1'b0, cfg.dev_pos} + 4'd1))
                  ? tot_sat - {1'b0, cfg.dev_pos} - 4'd1 : 4'd0;
        if (cfg.ir_width == 6'd0) ir_len = 6'd1;
        else if (cfg.ir_width > 6'd32) ir_len = 6'd32;
        else ir_len = cfg.ir_width;
    end

    function automatic logic [10:0] plen(input jdse_pkg::t_phase p, input logic [2:0] op,
            input logic [5:0] slast, input jdse_pkg::t_cfg c, input logic [3:0] da,
            input logic [5:0] il);
        logic [10:0] l;
        case (p)
            jdse_pkg::PH_SEQ:   l = 11'(slast) + 11'd1;
            jdse_pkg::PH_HEAD:  l = (op == jdse_pkg::OP_IR) ? 11'd4 : 11'd3;
            jdse_pkg::PH_PRE:   l = (op == jdse_pkg::OP_IR) ? 11'(c.ir_pre) : 11'(c.dev_pos);
            jdse_pkg::PH_REQ:   l = 11'd3;
            jdse_pkg::PH_DATA:  l = (op == jdse_pkg::OP_IR) ? 11'(il) : 11'd32;
            jdse_pkg::PH_POST:  l = (op == jdse_pkg::OP_IR) ? 11'(c.ir_post)
                                  : (op == jdse_pkg::OP_IDCODE) ? 11'd0 : 11'(da);
            jdse_pkg::PH_EXIT:  l = 11'd2;
            jdse_pkg::PH_ABORT: l = 11'd3;
            jdse_pkg::PH_RTI:   l = 11'(c.idle_clocks);
            default:            l = 11'd0;
        endcase
        return l;
    endfunction

    logic [2:0] ack_new;
    logic reading;
    logic [10:0] len;
    logic last;
    jdse_pkg::t_phase np;
    logic t_tms, t_tdi, t_fin;
    logic [2:0] t_ack;
    logic [63:0] t_rv;

    always_comb begin
        reading = (r_op == jdse_pkg::OP_IDCODE) || (r_op == jdse_pkg::OP_XFER && r_rnw);
        n_phase = r_phase; n_cnt = r_cnt; n_sout = r_sout; n_sin = r_sin;
        n_op = r_op; n_rnw = r_rnw; n_stms = r_stms; n_scap = r_scap;
        n_addr = r_addr; n_ack = r_ack; n_slast = r_slast;
        t_tms = 1'b0; t_tdi = 1'b1; t_fin = 1'b0; t_ack = 3'd0; t_rv = 64'd0;
        ack_new = r_ack;
        np = r_phase;
        len = plen(r_phase, r_op, r_slast, cfg, dev_after, ir_len);
        last = (r_cnt + 11'd1) >= len;

        // capture
        if (r_phase == jdse_pkg::PH_SEQ ||
                (r_phase == jdse_pkg::PH_DATA && reading)) begin
            n_sin[r_cnt[5:0]] = r_sin[r_cnt[5:0]] | i_tdo_bit;
        end
        if (r_phase == jdse_pkg::PH_REQ) begin
            if (r_cnt[1:0] != 2'd3) ack_new[r_cnt[1:0]] = r_ack[r_cnt[1:0]] | i_tdo_bit;
            if (r_cnt >= 11'd2 && r_op == jdse_pkg::OP_XFER)
                ack_new = jdse_pkg::ack_remap(ack_new);
            n_ack = ack_new;
        end

        // successor walk: at most one empty phase is skipped
        if (last) begin
            case (r_phase)
                jdse_pkg::PH_HEAD: np = jdse_pkg::PH_PRE;
                jdse_pkg::PH_PRE:  np = (r_op == jdse_pkg::OP_ABORT || r_op == jdse_pkg::OP_XFER)
                                        ? jdse_pkg::PH_REQ : jdse_pkg::PH_DATA;
                jdse_pkg::PH_REQ:  np = (r_op == jdse_pkg::OP_XFER && ack_new != jdse_pkg::AckOk)
                                        ? jdse_pkg::PH_ABORT : jdse_pkg::PH_DATA;
                jdse_pkg::PH_DATA: np = jdse_pkg::PH_POST;
                jdse_pkg::PH_POST: np = jdse_pkg::PH_EXIT;
                jdse_pkg::PH_EXIT: np = (r_op == jdse_pkg::OP_XFER)
                                        ? jdse_pkg::PH_RTI : jdse_pkg::PH_IDLE;
                jdse_pkg::PH_ABORT: np = jdse_pkg::PH_RTI;
                default: np = jdse_pkg::PH_IDLE;
            endcase
            // PRE may be empty, DATA never, POST may be, RTI may be
            if (np == jdse_pkg::PH_PRE &&
                    plen(jdse_pkg::PH_PRE, r_op, r_slast, cfg, dev_after, ir_len) == 11'd0)
                np = (r_op == jdse_pkg::OP_ABORT || r_op == jdse_pkg::OP_XFER)
                     ? jdse_pkg::PH_REQ : jdse_pkg::PH_DATA;
            if (np == jdse_pkg::PH_POST &&
                    plen(jdse_pkg::PH_POST, r_op, r_slast, cfg, dev_after, ir_len) == 11'd0)
                np = jdse_pkg::PH_EXIT;
            if (np == jdse_pkg::PH_RTI && cfg.idle_clocks == 8'd0)
                np = jdse_pkg::PH_IDLE;
        end

        case (r_phase)
            jdse_pkg::PH_SEQ: begin
                t_tms = r_stms;
                t_tdi = r_sout[r_cnt[5:0]];
            end
            jdse_pkg::PH_HEAD:
                t_tms = (r_cnt == 11'd0) || (r_cnt == 11'd1 && r_op == jdse_pkg::OP_IR);
            jdse_pkg::PH_REQ: begin
                if (r_op == jdse_pkg::OP_XFER) begin
                    case (r_cnt)
                        11'd0:   t_tdi = r_rnw;
                        11'd1:   t_tdi = r_addr[0];
                        11'd2:   t_tdi = r_addr[1];
                        default: t_tdi = 1'b0;
                    endcase
                end else begin
                    t_tdi = 1'b0;
                end
                t_tms = (np == jdse_pkg::PH_EXIT);
            end
            jdse_pkg::PH_DATA: begin
                if (!reading) t_tdi = r_sout[r_cnt[5:0]];
                t_tms = (np == jdse_pkg::PH_EXIT);
            end
            jdse_pkg::PH_PRE, jdse_pkg::PH_POST: t_tms = (np == jdse_pkg::PH_EXIT);
            jdse_pkg::PH_EXIT:  t_tms = (r_cnt == 11'd0);
            jdse_pkg::PH_ABORT: t_tms = (r_cnt < 11'd2);
            default: t_tms = 1'b0;
        endcase

        if (np == jdse_pkg::PH_IDLE && r_phase != jdse_pkg::PH_IDLE) begin
            t_fin = 1'b1;
            if (r_op == jdse_pkg::OP_XFER) begin
                t_ack = n_ack;
                if (r_rnw && n_ack == jdse_pkg::AckOk) t_rv = {32'd0, n_sin[31:0]};
            end else if (r_op == jdse_pkg::OP_IDCODE) begin
                t_rv = {32'd0, n_sin[31:0]};
            end else if (r_op == jdse_pkg::OP_SEQ && r_scap) begin
                t_rv = n_sin;
            end
        end

        if (r_phase != jdse_pkg::PH_IDLE) begin
            if (np != r_phase) begin
                n_phase = np; n_cnt = 11'd0;
            end else begin
                n_cnt = r_cnt + 11'd1;
            end
        end

        if (i_opcode != jdse_pkg::OP_TICK) begin
            n_phase = r_phase; n_cnt = r_cnt; n_sin = r_sin; n_ack = r_ack;
            if (r_phase == jdse_pkg::PH_IDLE && i_opcode <= jdse_pkg::OP_XFER) begin
                n_op = i_opcode; n_rnw = i_read_not_write; n_addr = i_reg_addr;
                n_stms = i_seq_tms; n_scap = i_seq_capture;
                n_slast = (i_seq_clocks == 6'd0) ? 6'(jdse_pkg::MaxSeqClocks - 1)
                                                 : i_seq_clocks - 6'd1;
                n_sout = i_payload; n_sin = 64'd0; n_ack = 3'd0; n_cnt = 11'd0;
                n_phase = (i_opcode == jdse_pkg::OP_SEQ) ? jdse_pkg::PH_SEQ
                                                        : jdse_pkg::PH_HEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jdse_pkg::PH_IDLE; r_cnt <= 11'd0; r_op <= 3'd0;
            r_ack <= 3'd0; r_slast <= 6'd0; r_sin <= 64'd0; r_sout <= 64'd0;
            r_rnw <= 1'b0; r_addr <= 2'd0; r_stms <= 1'b0; r_scap <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_op <= n_op; r_ack <= n_ack;
                r_slast <= n_slast; r_sin <= n_sin; r_sout <= n_sout; r_rnw <= n_rnw;
                r_addr <= n_addr; r_stms <= n_stms; r_scap <= n_scap;
            end
            if (take && i_opcode == jdse_pkg::OP_TICK) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (take && i_opcode == jdse_pkg::OP_TICK) begin
                if (r_phase == jdse_pkg::PH_IDLE) begin
                    r_tms <= 1'b0; r_tdi <= 1'b0; r_act <= 1'b0; r_fin <= 1'b0;
                    r_ackout <= 3'd0; r_rv <= 64'd0;
                end else begin
                    r_tms <= t_tms; r_tdi <= t_tdi; r_act <= 1'b1; r_fin <= t_fin;
                    r_ackout <= t_ack; r_rv <= t_rv;
                end
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_tms_bit = r_tms;
    assign o_tdi_bit = r_tdi;
    assign o_clock_active = r_act;
    assign o_finished = r_fin;
    assign o_ack_code = r_ackout;
    assign o_read_value = r_rv;

    `JDSE_ASSERT_NXT(a_hold_on_stall, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `JDSE_ASSERT_IMP(a_fin_active, i_clk, i_rst_n, o_valid && o_finished, o_clock_active)
    `JDSE_ASSERT_IMP(a_ack_only_fin, i_clk, i_rst_n, o_valid && !o_finished,
        o_ack_code == 3'd0 && o_read_value == 64'd0)
endmodule
`default_nettype wire

// ----- rtl/jdse_cfg_regs.sv -----
//------------------------------------------------------------------------------
// jdse_cfg_regs
// Configuration register file of the JTAG scan engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module jdse_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [9:0]   i_cfg_data,
    output jdse_pkg::t_cfg    o_cfg
);
    jdse_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dev_pos: 3'd0, dev_total: 4'd1, ir_pre: 10'd0,
                       ir_post: 10'd0, ir_width: 6'd4, idle_clocks: 8'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jdse_pkg::REG_DEV_POS:   r_cfg.dev_pos     <= i_cfg_data[2:0];
                jdse_pkg::REG_DEV_TOTAL: r_cfg.dev_total   <= i_cfg_data[3:0];
                jdse_pkg::REG_IR_PRE:    r_cfg.ir_pre      <= i_cfg_data;
                jdse_pkg::REG_IR_POST:   r_cfg.ir_post     <= i_cfg_data;
                jdse_pkg::REG_IR_WIDTH:  r_cfg.ir_width    <= i_cfg_data[5:0];
                jdse_pkg::REG_IDLE:      r_cfg.idle_clocks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ----- tb/jtag_dap_scan_engine_core_tb.sv -----
//------------------------------------------------------------------------------
// jtag_dap_scan_engine_core_tb
// Drives command and tick items into the scan engine, predicts every tick's
// TMS/TDI/finish/ACK/read data with a cycle-free model of the phase walk, and
// checks each result in order. Walks a short directed table, then random
// operations over several chain setups and idle/stall mixes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module jtag_dap_scan_engine_core_tb;
    localparam int WatchdogLimit = 20000;
    localparam int ItemsPerSetup = 160;
    localparam int SetupCount    = 8;
    localparam logic [2:0] JtagToSwdAck [8] =
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd7};

    typedef struct {
        logic [2:0]  opcode;
        logic        tdo;
        logic [63:0] payload;
        logic        rnw;
        logic [1:0]  addr;
        logic [5:0]  clocks;
        logic        tms;
        logic        cap;
    } t_scan_item;

    typedef struct {
        bit        tms;
        bit        tdi;
        bit        clk_on;
        bit        fin;
        bit [2:0]  ack;
        bit [63:0] rv;
    } t_tick_result;

    // directed row: item, then (fill) ticks until the operation ends, TDO from pat
    typedef struct {
        t_scan_item  item;
        bit          fill;
        logic [63:0] pat;
        bit          typed;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic        i_tdo_bit;
    logic [63:0] i_payload;
    logic        i_read_not_write;
    logic [1:0]  i_reg_addr;
    logic [5:0]  i_seq_clocks;
    logic        i_seq_tms;
    logic        i_seq_capture;
    logic        o_valid;
    logic        i_stall;
    logic        o_tms_bit;
    logic        o_tdi_bit;
    logic        o_clock_active;
    logic        o_finished;
    logic [2:0]  o_ack_code;
    logic [63:0] o_read_value;

    jtag_dap_scan_engine_core dut (.*);

    // chain setup and engine state as the predictor sees them
    logic [2:0]  c_pos;
    logic [3:0]  c_total;
    logic [9:0]  c_ir_pre;
    logic [9:0]  c_ir_post;
    logic [5:0]  c_ir_width;
    logic [7:0]  c_idle;
    jdse_pkg::t_phase st_phase;
    logic [10:0] st_cnt;
    logic [63:0] st_out;
    logic [63:0] st_in;
    logic [7:0]  st_cmd;
    logic [2:0]  st_ack;
    int unsigned st_seq_last;

    t_tick_result expected_ticks[$];
    int          errors;
    int          items_sent;
    int          idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both light
    int          quiet_cycles;
    t_dir_row    dir_rows[17];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned devices_after();
        int unsigned total = (c_total > jdse_pkg::MaxChainDevices)
                           ? jdse_pkg::MaxChainDevices : c_total;
        return (total > c_pos + 1) ? total - c_pos - 1 : 0;
    endfunction

    function automatic int unsigned phase_len(jdse_pkg::t_phase p);
        logic [2:0] op = st_cmd[2:0];
        case (p)
            jdse_pkg::PH_SEQ:   return st_seq_last + 1;
            jdse_pkg::PH_HEAD:  return (op == jdse_pkg::OP_IR) ? 4 : 3;
            jdse_pkg::PH_PRE:   return (op == jdse_pkg::OP_IR) ? 32'(c_ir_pre) : 32'(c_pos);
            jdse_pkg::PH_REQ:   return 3;
            jdse_pkg::PH_DATA:  begin
                if (op != jdse_pkg::OP_IR) return 32;
                if (c_ir_width == 0) return 1;
                return (c_ir_width > 32) ? 32 : 32'(c_ir_width);
            end
            jdse_pkg::PH_POST:  begin
                if (op == jdse_pkg::OP_IR) return 32'(c_ir_post);
                return (op == jdse_pkg::OP_IDCODE) ? 0 : devices_after();
            end
            jdse_pkg::PH_EXIT:  return 2;
            jdse_pkg::PH_ABORT: return 3;
            jdse_pkg::PH_RTI:   return 32'(c_idle);
            default:            return 0;
        endcase
    endfunction

    function automatic jdse_pkg::t_phase phase_after(jdse_pkg::t_phase p);
        logic [2:0] op = st_cmd[2:0];
        case (p)
            jdse_pkg::PH_HEAD:  return jdse_pkg::PH_PRE;
            jdse_pkg::PH_PRE:
                return (op == jdse_pkg::OP_ABORT || op == jdse_pkg::OP_XFER)
                       ? jdse_pkg::PH_REQ : jdse_pkg::PH_DATA;
            jdse_pkg::PH_REQ:
                return (op == jdse_pkg::OP_XFER && st_ack != jdse_pkg::AckOk)
                       ? jdse_pkg::PH_ABORT : jdse_pkg::PH_DATA;
            jdse_pkg::PH_DATA:  return jdse_pkg::PH_POST;
            jdse_pkg::PH_POST:  return jdse_pkg::PH_EXIT;
            jdse_pkg::PH_EXIT:
                return (op == jdse_pkg::OP_XFER) ? jdse_pkg::PH_RTI : jdse_pkg::PH_IDLE;
            jdse_pkg::PH_ABORT: return jdse_pkg::PH_RTI;
            default:            return jdse_pkg::PH_IDLE;
        endcase
    endfunction

    function automatic jdse_pkg::t_phase next_busy_phase(jdse_pkg::t_phase p);
        jdse_pkg::t_phase q = phase_after(p);
        while (q != jdse_pkg::PH_IDLE && phase_len(q) == 0) q = phase_after(q);
        return q;
    endfunction

    // advances the engine model by one item; returns 1 if the item yields a result
    function automatic bit predict_tick(input t_scan_item it, output t_tick_result r);
        logic [2:0]  op;
        int unsigned idx;
        jdse_pkg::t_phase np;
        bit          reading;
        r = '{default: 0};
        if (it.opcode != jdse_pkg::OP_TICK) begin
            if (st_phase != jdse_pkg::PH_IDLE || it.opcode > jdse_pkg::OP_XFER) return 0;
            st_cmd      = {it.cap, it.tms, it.addr, it.rnw, it.opcode};
            st_seq_last = (it.clocks == 0) ? jdse_pkg::MaxSeqClocks - 1 : it.clocks - 1;
            st_out      = it.payload;
            st_in       = '0;
            st_ack      = '0;
            st_cnt      = '0;
            st_phase    = (it.opcode == jdse_pkg::OP_SEQ) ? jdse_pkg::PH_SEQ
                                                          : jdse_pkg::PH_HEAD;
            return 0;
        end
        if (st_phase == jdse_pkg::PH_IDLE) return 1;

        op      = st_cmd[2:0];
        idx     = 32'(st_cnt);
        reading = (op == jdse_pkg::OP_IDCODE) || (op == jdse_pkg::OP_XFER && st_cmd[3]);

        if (st_phase == jdse_pkg::PH_SEQ || (st_phase == jdse_pkg::PH_DATA && reading))
            st_in |= 64'(it.tdo) << idx[5:0];
        else if (st_phase == jdse_pkg::PH_REQ) begin
            st_ack |= 3'(it.tdo << idx[1:0]);
            if (idx + 1 >= 3 && op == jdse_pkg::OP_XFER) st_ack = JtagToSwdAck[st_ack];
        end

        np = (idx + 1 >= phase_len(st_phase)) ? next_busy_phase(st_phase) : st_phase;
        r.tdi = 1'b1;
        case (st_phase)
            jdse_pkg::PH_SEQ: begin
                r.tms = st_cmd[6];
                r.tdi = st_out[idx[5:0]];
            end
            jdse_pkg::PH_HEAD: r.tms = (idx == 0) || (idx == 1 && op == jdse_pkg::OP_IR);
            jdse_pkg::PH_REQ: begin
                r.tdi = (op == jdse_pkg::OP_XFER && idx < 3) ? st_cmd[3 + idx] : 1'b0;
                r.tms = (np == jdse_pkg::PH_EXIT);
            end
            jdse_pkg::PH_DATA: begin
                if (!reading) r.tdi = st_out[idx[5:0]];
                r.tms = (np == jdse_pkg::PH_EXIT);
            end
            jdse_pkg::PH_PRE, jdse_pkg::PH_POST: r.tms = (np == jdse_pkg::PH_EXIT);
            jdse_pkg::PH_EXIT:  r.tms = (idx == 0);
            jdse_pkg::PH_ABORT: r.tms = (idx < 2);
            default:            r.tms = 1'b0;
        endcase
        r.clk_on = 1'b1;

        if (np != st_phase) begin
            st_phase = np;
            st_cnt   = '0;
        end else begin
            st_cnt = st_cnt + 1'b1;
        end

        if (st_phase == jdse_pkg::PH_IDLE) begin
            r.fin = 1'b1;
            if (op == jdse_pkg::OP_XFER) begin
                r.ack = st_ack;
                if (st_cmd[3] && st_ack == jdse_pkg::AckOk) r.rv = {32'd0, st_in[31:0]};
            end else if (op == jdse_pkg::OP_IDCODE) begin
                r.rv = {32'd0, st_in[31:0]};
            end else if (op == jdse_pkg::OP_SEQ && st_cmd[7]) begin
                r.rv = st_in;
            end
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, field, got, want);
        errors++;
    endtask

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin
        t_tick_result w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_tms_bit), 64'd0);
                end else begin
                    w = expected_ticks.pop_front();
                    if (o_tms_bit !== w.tms)
                        report_mismatch("tms_bit", 64'(o_tms_bit), 64'(w.tms));
                    if (o_tdi_bit !== w.tdi)
                        report_mismatch("tdi_bit", 64'(o_tdi_bit), 64'(w.tdi));
                    if (o_clock_active !== w.clk_on)
                        report_mismatch("clock_active", 64'(o_clock_active), 64'(w.clk_on));
                    if (o_finished !== w.fin)
                        report_mismatch("finished", 64'(o_finished), 64'(w.fin));
                    if (o_ack_code !== w.ack)
                        report_mismatch("ack_code", 64'(o_ack_code), 64'(w.ack));
                    if (o_read_value !== w.rv)
                        report_mismatch("read_value", o_read_value, w.rv);
                end
            end
            case (idle_mode)
                2:       i_stall <= ($urandom_range(99) < 83);
                3:       i_stall <= ($urandom_range(99) < 16);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("jtag_dap_scan_engine_core_tb failed");
                $finish;
            end
        end
    end

    task automatic send_item(input t_scan_item it, input bit typed);
        t_tick_result r;
        while ((idle_mode == 1 && $urandom_range(99) < 83) ||
               (idle_mode == 3 && $urandom_range(99) < 16)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= it.opcode;
        i_tdo_bit        <= it.tdo;
        i_payload        <= it.payload;
        i_read_not_write <= it.rnw;
        i_reg_addr       <= it.addr;
        i_seq_clocks     <= it.clocks;
        i_seq_tms        <= it.tms;
        i_seq_capture    <= it.cap;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (predict_tick(it, r)) begin
            if (typed) r = '{default: 0};
            expected_ticks.push_back(r);
        end
    endtask

    function automatic t_scan_item random_item(input logic [2:0] opcode);
        t_scan_item it;
        it.opcode  = opcode;
        it.tdo     = 1'($urandom_range(1));
        it.payload = {$urandom, $urandom};
        it.rnw     = 1'($urandom_range(1));
        it.addr    = 2'($urandom_range(3));
        it.clocks  = 6'($urandom_range(63));
        it.tms     = 1'($urandom_range(1));
        it.cap     = 1'($urandom_range(1));
        return it;
    endfunction

    // IR pad length: mostly short, sometimes anywhere in range
    function automatic logic [9:0] pick_ir_pad();
        if ($urandom_range(9) == 0) return 10'($urandom_range(1023));
        return 10'($urandom_range(6));
    endfunction

    task automatic send_tick(input logic tdo);
        t_scan_item it = random_item(jdse_pkg::OP_TICK);
        it.tdo = tdo;
        send_item(it, 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setup(input logic [9:0] v [6]);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data  <= v[k];
            @(posedge i_clk);
            case (jdse_pkg::t_reg'(k))
                jdse_pkg::REG_DEV_POS:   c_pos      = v[k][2:0];
                jdse_pkg::REG_DEV_TOTAL: c_total    = v[k][3:0];
                jdse_pkg::REG_IR_PRE:    c_ir_pre   = v[k];
                jdse_pkg::REG_IR_POST:   c_ir_post  = v[k];
                jdse_pkg::REG_IR_WIDTH:  c_ir_width = v[k][5:0];
                jdse_pkg::REG_IDLE:      c_idle     = v[k][7:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [9:0]  setup [6];
        int          k;
        logic        tdo;

        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_opcode = '0; i_tdo_bit = 1'b0; i_payload = '0;
        i_read_not_write = 1'b0; i_reg_addr = '0; i_seq_clocks = '0;
        i_seq_tms = 1'b0; i_seq_capture = 1'b0;
        errors = 0; items_sent = 0; idle_mode = 0; quiet_cycles = 0;
        c_pos = 3'd0; c_total = 4'd1; c_ir_pre = 10'd0; c_ir_post = 10'd0;
        c_ir_width = 6'd4; c_idle = 8'd0;
        st_phase = jdse_pkg::PH_IDLE; st_cnt = '0; st_out = '0; st_in = '0;
        st_cmd = '0; st_ack = '0; st_seq_last = 0;

        // default chain: one device, 4-bit IR, no idle clocks; REQ ticks are 3..5
        dir_rows = '{
            '{'{jdse_pkg::OP_TICK, 1'b0, 64'd0, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b0, 64'd0, 1'b1},
            '{'{3'd6, 1'b1, '1, 1'b1, 2'd3, 6'd63, 1'b1, 1'b1}, 1'b0, 64'd0, 1'b0},
            '{'{3'd7, 1'b0, '1, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0}, 1'b0, 64'd0, 1'b0},
            '{'{jdse_pkg::OP_SEQ, 1'b0, '1, 1'b0, 2'd0, 6'd1, 1'b1, 1'b1},
              1'b1, '1, 1'b0},
            '{'{jdse_pkg::OP_SEQ, 1'b0, 64'd0, 1'b0, 2'd0, 6'd0, 1'b0, 1'b1},
              1'b1, 64'hC3A5_0F96_7E18_B24D, 1'b0},
            '{'{jdse_pkg::OP_SEQ, 1'b0, 64'hFFFF, 1'b0, 2'd0, 6'd63, 1'b0, 1'b0},
              1'b1, '1, 1'b0},
            '{'{jdse_pkg::OP_IDCODE, 1'b0, 64'd0, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h1BA0_1477_0000_0000, 1'b0},
            '{'{jdse_pkg::OP_ABORT, 1'b0, 64'hFFFF_FFFF, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h38, 1'b0},
            '{'{jdse_pkg::OP_IR, 1'b0, 64'hF, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b1, '1, 1'b0},
            '{'{jdse_pkg::OP_XFER, 1'b0, 64'hFFFF_FFFF, 1'b0, 2'd3, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h10, 1'b0},
            '{'{jdse_pkg::OP_XFER, 1'b0, 64'd0, 1'b1, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b1, 64'hFFFF_FFFF_FFFF_FFD7, 1'b0},
            '{'{jdse_pkg::OP_XFER, 1'b0, 64'd0, 1'b1, 2'd1, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h08, 1'b0},
            '{'{jdse_pkg::OP_XFER, 1'b0, '1, 1'b0, 2'd2, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h20, 1'b0},
            '{'{jdse_pkg::OP_XFER, 1'b0, 64'd0, 1'b1, 2'd3, 6'd0, 1'b0, 1'b0},
              1'b1, 64'h0, 1'b0},
            '{'{jdse_pkg::OP_IDCODE, 1'b0, 64'd0, 1'b0, 2'd0, 6'd0, 1'b0, 1'b0},
              1'b0, 64'd0, 1'b0},
            '{'{jdse_pkg::OP_SEQ, 1'b0, '1, 1'b1, 2'd1, 6'd5, 1'b1, 1'b1},
              1'b1, 64'h5555_AAAA_5555_AAAA, 1'b0},
            '{'{jdse_pkg::OP_TICK, 1'b1, '1, 1'b1, 2'd3, 6'd63, 1'b1, 1'b1},
              1'b0, 64'd0, 1'b1}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].typed);
            k = 0;
            while (dir_rows[r].fill && st_phase != jdse_pkg::PH_IDLE) begin
                send_tick(dir_rows[r].pat[k % 64]);
                k++;
            end
        end

        for (int s = 0; s < SetupCount; s++) begin
            wait_drained();
            if (s == 3) begin
                setup = '{10'd7, 10'd15, 10'd1023, 10'd1023, 10'd63, 10'd255};
            end else if (s == 5) begin
                setup = '{default: 10'd0};
            end else begin
                setup = '{10'($urandom_range(7)), 10'($urandom_range(15)),
                          pick_ir_pad(), pick_ir_pad(),
                          10'($urandom_range(63)), 10'($urandom_range(4))};
            end
            write_setup(setup);
            idle_mode = s % 4;
            while (items_sent < ItemsPerSetup * (s + 1)) begin
                // mostly whole operations; some noise and abandoned ones
                if ($urandom_range(19) == 0)
                    send_item(random_item(3'($urandom_range(6, 7))), 1'b0);
                send_item(random_item(3'($urandom_range(jdse_pkg::OP_SEQ,
                                                        jdse_pkg::OP_XFER))), 1'b0);
                while (st_phase != jdse_pkg::PH_IDLE) begin
                    if ($urandom_range(99) < 3) break;
                    if ($urandom_range(99) < 4)
                        send_item(random_item(3'($urandom_range(jdse_pkg::OP_SEQ, 7))),
                                  1'b0);
                    // bias the ACK toward OK so data phases are reached
                    if (st_phase == jdse_pkg::PH_REQ && $urandom_range(99) < 80)
                        tdo = (st_cnt == 11'd1);
                    else
                        tdo = 1'($urandom_range(1));
                    send_tick(tdo);
                end
                if ($urandom_range(9) == 0) send_tick(1'($urandom_range(1)));
            end
        end

        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("jtag_dap_scan_engine_core_tb passed");
        else
            $display("jtag_dap_scan_engine_core_tb failed");
        $finish;
    end
endmodule
